FILE: src/dlrs_pkg.sv
package dlrs_pkg;

    localparam int MaxItems = 64;
    localparam int Radix = 10;
    localparam int ValueW = 30;
    localparam int DigitsW = 4;
    localparam int AddrW = $clog2(MaxItems);
    localparam int CountW = $clog2(MaxItems + 1);
    localparam int DigW = 4;
    localparam int NumPosW = 5;

    localparam logic [DigitsW-1:0] DigitsReset = 4'd6;

    typedef logic [ValueW-1:0] value_t;
    typedef logic [CountW-1:0] count_t;
    typedef logic [AddrW-1:0] addr_t;
    typedef logic [DigW-1:0] digit_t;

    // One decimal digit step: quotient by ten and remainder, via reciprocal.
    // q = floor(v * 0xCCCCCCCD / 2^35) is exact for all 32-bit v.
    typedef struct packed {
        value_t quot;
        digit_t rem;
    } divten_t;

    function automatic divten_t div_ten(input value_t v);
        logic [65:0] prod;
        value_t q;
        logic [ValueW+3:0] back;
        divten_t r;
        begin
            prod = {36'd0, v} * 66'h0CCCCCCCD;
            q = prod[35+ValueW-1:35];
            back = {4'd0, q} * 34'd10;
            r.quot = q;
            r.rem = DigW'(v - back[ValueW-1:0]);
            return r;
        end
    endfunction

endpackage

FILE: src/dlrs_if.sv
interface dlrs_in_if;
    logic valid;
    logic ready;
    logic [dlrs_pkg::ValueW-1:0] value;
    logic last;
    modport source (output valid, output value, output last, input ready);
    modport sink (input valid, input value, input last, output ready);
endinterface

interface dlrs_out_if;
    logic valid;
    logic ready;
    logic [dlrs_pkg::ValueW-1:0] sorted_value;
    logic last_res;
    logic overflow;
    modport source (output valid, output sorted_value, output last_res, output overflow,
                    input ready);
    modport sink (input valid, input sorted_value, input last_res, input overflow,
                  output ready);
endinterface

interface dlrs_cfg_if;
    logic valid;
    logic ready;
    logic [dlrs_pkg::DigitsW-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/decimal_lsd_radix_sort_top.sv
// Channel  Dir  Payload                               Handshake
// in       in   value[29:0], last                     valid/ready
// out      out  sorted_value[29:0], last_res, overflow valid/ready
// cfg      in   data[3:0] (num_digits)                valid/ready
//
// Load: one cycle per word; in and cfg are ready only while loading.
// Sort after a last word: num_digits passes; at pass pos the digit is the remainder
// after pos-1 divides by ten, and digits past the tenth read as zero.
// The single shared divide-by-ten unit, one quotient step per cycle, sets the rate.
// Output: a word is read only after the one before is taken; out.ready low holds the word.
// Async active-low reset; no clearing pass.
module decimal_lsd_radix_sort_top (
    input logic clk,
    input logic rst_n,
    dlrs_in_if.sink in,
    dlrs_out_if.source out,
    dlrs_cfg_if.sink cfg
);

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_PASS  = 4'd1;
    localparam logic [3:0] S_CRD   = 4'd2;
    localparam logic [3:0] S_CDIV  = 4'd3;
    localparam logic [3:0] S_PRE   = 4'd4;
    localparam logic [3:0] S_PRD   = 4'd5;
    localparam logic [3:0] S_PDIV  = 4'd6;
    localparam logic [3:0] S_CPRD  = 4'd7;
    localparam logic [3:0] S_CPWR  = 4'd8;
    localparam logic [3:0] S_ORD   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_CPWT  = 4'd11;
    localparam logic [3:0] S_OLD   = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [dlrs_pkg::DigitsW-1:0] num_digits_reg;
    dlrs_pkg::count_t item_count_reg;
    logic dropped_reg;
    logic [dlrs_pkg::NumPosW-1:0] pos_reg;
    logic [dlrs_pkg::NumPosW-1:0] step_reg;
    dlrs_pkg::count_t idx_reg;
    dlrs_pkg::value_t work_reg;
    dlrs_pkg::value_t rd_a_reg;
    dlrs_pkg::value_t rd_b_reg;
    dlrs_pkg::count_t cnt_reg [dlrs_pkg::Radix];
    dlrs_pkg::count_t pre_acc_reg;
    logic [3:0] pre_idx_reg;
    dlrs_pkg::value_t out_val_reg;
    logic out_last_reg, out_ovf_reg, out_valid_reg;

    dlrs_pkg::value_t mem_a [dlrs_pkg::MaxItems];
    dlrs_pkg::value_t mem_b [dlrs_pkg::MaxItems];

    dlrs_pkg::divten_t dt;
    dlrs_pkg::digit_t dig;
    logic in_acc, cfg_acc, out_acc;
    logic key_done;
    dlrs_pkg::addr_t idx_a;
    dlrs_pkg::count_t slot;

    assign in.ready = (state_reg == S_LOAD);
    assign cfg.ready = (state_reg == S_LOAD);
    assign in_acc = in.valid && in.ready;
    assign cfg_acc = cfg.valid && cfg.ready;
    assign out_acc = out_valid_reg && out.ready;
    assign out.valid = out_valid_reg;
    assign out.sorted_value = out_val_reg;
    assign out.last_res = out_last_reg;
    assign out.overflow = out_ovf_reg;

    // first key cycle divides the read word, later ones the running quotient
    assign dt = dlrs_pkg::div_ten((step_reg == '0) ? rd_a_reg : work_reg);
    // step counts divides done; digit at pos is remainder after pos-1 quotients
    assign key_done = (step_reg + dlrs_pkg::NumPosW'(1) >= pos_reg)
                      || (pos_reg > dlrs_pkg::NumPosW'(10));
    assign dig = (pos_reg > dlrs_pkg::NumPosW'(10)) ? '0 : dt.rem;
    assign idx_a = idx_reg[dlrs_pkg::AddrW-1:0];
    assign slot = cnt_reg[dig] - 1'b1;

    always_ff @(posedge clk)
    begin
        if (in_acc && item_count_reg < dlrs_pkg::CountW'(dlrs_pkg::MaxItems))
        begin
            mem_a[item_count_reg[dlrs_pkg::AddrW-1:0]] <= in.value;
        end
        else if (state_reg == S_CPWR)
        begin
            mem_a[idx_a] <= rd_b_reg;
        end
        if (state_reg == S_PDIV && key_done)
        begin
            mem_b[slot[dlrs_pkg::AddrW-1:0]] <= rd_a_reg;
        end
        rd_a_reg <= mem_a[idx_a];
        rd_b_reg <= mem_b[idx_a];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_acc && in.last)
                begin
                    state_next = S_PASS;
                end
            end
            S_PASS:
            begin
                if (pos_reg > {1'b0, num_digits_reg})
                begin
                    state_next = S_ORD;
                end
                else
                begin
                    state_next = S_CRD;
                end
            end
            S_CRD:
            begin
                if (idx_reg == item_count_reg)
                begin
                    state_next = S_PRE;
                end
                else
                begin
                    state_next = S_CDIV;
                end
            end
            S_CDIV:
            begin
                if (key_done)
                begin
                    state_next = S_CRD;
                end
            end
            S_PRE:
            begin
                if (pre_idx_reg == 4'd9)
                begin
                    state_next = S_PRD;
                end
            end
            S_PRD:
            begin
                state_next = S_PDIV;
            end
            S_PDIV:
            begin
                if (key_done)
                begin
                    state_next = (idx_reg == '0) ? S_CPRD : S_PRD;
                end
            end
            S_CPRD:
            begin
                if (idx_reg == item_count_reg)
                begin
                    state_next = S_PASS;
                end
                else
                begin
                    state_next = S_CPWT;
                end
            end
            S_CPWT:
            begin
                state_next = S_CPWR;
            end
            S_CPWR:
            begin
                state_next = S_CPRD;
            end
            S_ORD:
            begin
                state_next = S_OLD;
            end
            S_OLD:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_acc)
                begin
                    state_next = out_last_reg ? S_LOAD : S_ORD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            num_digits_reg <= dlrs_pkg::DigitsReset;
            item_count_reg <= '0;
            dropped_reg <= 1'b0;
            pos_reg <= '0;
            step_reg <= '0;
            idx_reg <= '0;
            pre_idx_reg <= '0;
            pre_acc_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int d = 0; d < dlrs_pkg::Radix; d++)
            begin
                cnt_reg[d] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_acc)
            begin
                num_digits_reg <= cfg.data;
            end
            if (out_acc)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_acc)
                    begin
                        if (item_count_reg < dlrs_pkg::CountW'(dlrs_pkg::MaxItems))
                        begin
                            item_count_reg <= item_count_reg + 1'b1;
                        end
                        else
                        begin
                            dropped_reg <= 1'b1;
                        end
                        pos_reg <= dlrs_pkg::NumPosW'(1);
                    end
                end
                S_PASS:
                begin
                    idx_reg <= '0;
                    for (int d = 0; d < dlrs_pkg::Radix; d++)
                    begin
                        cnt_reg[d] <= '0;
                    end
                end
                S_CRD:
                begin
                    // address presented this cycle; read data lands next
                    step_reg <= '0;
                end
                S_CDIV:
                begin
                    if (key_done)
                    begin
                        cnt_reg[dig] <= cnt_reg[dig] + 1'b1;
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_PRE:
                begin
                    cnt_reg[pre_idx_reg] <= pre_acc_reg + cnt_reg[pre_idx_reg];
                    if (pre_idx_reg == 4'd9)
                    begin
                        pre_idx_reg <= '0;
                        pre_acc_reg <= '0;
                        idx_reg <= item_count_reg - 1'b1;
                    end
                    else
                    begin
                        pre_idx_reg <= pre_idx_reg + 1'b1;
                        pre_acc_reg <= pre_acc_reg + cnt_reg[pre_idx_reg];
                    end
                end
                S_PRD:
                begin
                    step_reg <= '0;
                end
                S_PDIV:
                begin
                    if (key_done)
                    begin
                        cnt_reg[dig] <= slot;
                        if (idx_reg != '0)
                        begin
                            idx_reg <= idx_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_CPRD:
                begin
                    if (idx_reg == item_count_reg)
                    begin
                        pos_reg <= pos_reg + dlrs_pkg::NumPosW'(1);
                        idx_reg <= '0;
                    end
                end
                S_CPWT:
                begin
                end
                S_CPWR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                S_ORD:
                begin
                end
                S_OLD:
                begin
                    out_valid_reg <= 1'b1;
                end
                S_OUT:
                begin
                    if (out_acc)
                    begin
                        if (out_last_reg)
                        begin
                            item_count_reg <= '0;
                            dropped_reg <= 1'b0;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // running quotient for the digit extraction; output word register
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_CDIV || state_reg == S_PDIV) && !key_done)
        begin
            work_reg <= dt.quot;
        end
        if (state_reg == S_OLD)
        begin
            out_val_reg <= rd_a_reg;
            out_last_reg <= (idx_reg + 1'b1 == item_count_reg);
            out_ovf_reg <= dropped_reg;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        item_count_reg <= dlrs_pkg::CountW'(dlrs_pkg::MaxItems))
        else $error("item count above capacity");
    a_out_idle_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LOAD |-> !out_valid_reg)
        else $error("output valid during load");
    a_batch_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ORD |-> item_count_reg != '0)
        else $error("output of empty batch");
`endif

endmodule

FILE: tb/tb_decimal_lsd_radix_sort_top.sv
module tb_decimal_lsd_radix_sort_top;

    typedef struct {
        dlrs_pkg::value_t sorted_value;
        logic   last_res;
        logic   overflow;
    } sorted_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    dlrs_in_if  in_ch();
    dlrs_out_if out_ch();
    dlrs_cfg_if cfg_ch();

    decimal_lsd_radix_sort_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch.sink),
        .out   (out_ch.source),
        .cfg   (cfg_ch.sink)
    );

    always #2 clk = ~clk;

    // predictor state
    dlrs_pkg::value_t batch_store[$];
    logic           batch_dropped;
    logic [3:0]     digit_passes;
    sorted_word_t   sorted_pending[$];

    int  err_count = 0;
    int  idle_cycles = 0;
    bit  sink_hold = 1'b0;
    bit  timed_out = 1'b0;

    localparam int IdleLimit = 200000;

    function automatic int digit_of(dlrs_pkg::value_t v, int pos);
        logic [31:0] w;
        w = v;
        if (pos > 10)
            return 0;
        for (int k = 1; k < pos; k++)
            w = w / 10;
        return w % 10;
    endfunction

    task automatic sort_and_predict();
        dlrs_pkg::value_t a[$];
        dlrs_pkg::value_t b[];
        int cnt[10];
        int slot;
        int d;
        a = batch_store;
        b = new[a.size()];
        for (int p = 1; p <= digit_passes; p++)
        begin
            foreach (cnt[i]) cnt[i] = 0;
            foreach (a[i]) cnt[digit_of(a[i], p)]++;
            for (int i = 1; i < 10; i++) cnt[i] += cnt[i-1];
            for (int i = a.size() - 1; i >= 0; i--)
            begin
                d = digit_of(a[i], p);
                cnt[d]--;
                slot = cnt[d];
                b[slot] = a[i];
            end
            foreach (a[i]) a[i] = b[i];
        end
        foreach (a[i])
        begin
            sorted_word_t w;
            w.sorted_value = a[i];
            w.last_res = (i == a.size() - 1);
            w.overflow = batch_dropped;
            sorted_pending.insert(sorted_pending.size(), w);
        end
        batch_store.delete();
        batch_dropped = 1'b0;
    endtask

    task automatic clk_gap(int n);
        repeat (n) @(posedge clk);
    endtask

    function automatic int rand_gap();
        if ($urandom_range(0, 3) == 0)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // valid stays high after the accept; the caller drops it before idling
    task automatic send_word(dlrs_pkg::value_t v, logic lst);
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        in_ch.last  <= lst;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        if (batch_store.size() < dlrs_pkg::MaxItems)
            batch_store.insert(batch_store.size(), v);
        else
            batch_dropped = 1'b1;
        if (lst)
            sort_and_predict();
    endtask

    task automatic send_paced(dlrs_pkg::value_t v, logic lst);
        int g;
        g = rand_gap();
        if (g > 0)
        begin
            in_ch.valid <= 1'b0;
            clk_gap(g);
        end
        send_word(v, lst);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sorted_pending.size() != 0 && !timed_out) @(posedge clk);
        clk_gap(20);
    endtask

    task automatic write_digits(logic [3:0] nd);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= nd;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        digit_passes = nd;
    endtask

    function automatic dlrs_pkg::value_t rand_value();
        case ($urandom_range(0, 5))
            0: return dlrs_pkg::value_t'($urandom_range(0, 99));
            1: return dlrs_pkg::value_t'($urandom) ; // full 30-bit patterns
            2: return dlrs_pkg::value_t'($urandom_range(999999000, 999999999));
            default: return dlrs_pkg::value_t'($urandom_range(0, 999999999));
        endcase
    endfunction

    task automatic send_batch(int n);
        for (int i = 0; i < n; i++)
            send_paced(rand_value(), i == n - 1);
    endtask

    task automatic test_directed_extremes();
        write_digits(4'd9);
        send_paced(30'd999999999, 1'b0);
        send_paced(30'd0, 1'b0);
        send_paced(30'h3FFFFFFF, 1'b0);
        send_paced(30'd10, 1'b0);
        send_paced(30'd1, 1'b0);
        send_paced(30'd10, 1'b0);
        send_paced(30'd999999999, 1'b0);
        send_paced(30'd2, 1'b1);
        // single-word batch
        send_paced(30'd123456789, 1'b1);
    endtask

    task automatic test_digit_settings();
        write_digits(4'd0);
        send_batch(5);
        write_digits(4'd1);
        send_batch(6);
        write_digits(4'd15);
        send_batch(5);
    endtask

    task automatic test_overflow_stall();
        write_digits(4'd3);
        sink_hold = 1'b1;
        fork
            begin
                // long enough for the full batch to sort and wait on the sink
                clk_gap(2500);
                sink_hold = 1'b0;
            end
            begin
                for (int i = 0; i < dlrs_pkg::MaxItems + 2; i++)
                    send_word(dlrs_pkg::value_t'($urandom_range(0, 999999999)), 1'b0);
                send_word(30'd5, 1'b1);
                // further batches offered while the output is held
                send_batch(4);
                send_batch(3);
                in_ch.valid <= 1'b0;
            end
        join
    endtask

    task automatic test_random_batches();
        int sent;
        sent = 0;
        write_digits(4'd6);
        while (sent < 10)
        begin
            int n;
            n = $urandom_range(1, 12);
            if ($urandom_range(0, 4) == 0)
                write_digits(4'($urandom_range(1, 9)));
            send_batch(n);
            sent += n;
            if ($urandom_range(0, 5) == 0)
                drain();
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            sorted_word_t exp_w;
            if (sorted_pending.size() == 0)
            begin
                $error("unexpected word: sorted_value %0d", out_ch.sorted_value);
                err_count++;
            end
            else
            begin
                exp_w = sorted_pending.pop_front();
                if (out_ch.sorted_value !== exp_w.sorted_value)
                begin
                    $error("sorted_value exp %0d got %0d", exp_w.sorted_value,
                           out_ch.sorted_value);
                    err_count++;
                end
                if (out_ch.last_res !== exp_w.last_res)
                begin
                    $error("last_res exp %0b got %0b", exp_w.last_res, out_ch.last_res);
                    err_count++;
                end
                if (out_ch.overflow !== exp_w.overflow)
                begin
                    $error("overflow exp %0b got %0b", exp_w.overflow, out_ch.overflow);
                    err_count++;
                end
            end
        end
    end

    // sink pacing
    always @(posedge clk)
    begin
        if (sink_hold)
            out_ch.ready <= 1'b0;
        else if ($urandom_range(0, 9) < 2)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= 1'b1;
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit && !timed_out)
        begin
            timed_out = 1'b1;
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        in_ch.valid  = 1'b0;
        in_ch.value  = '0;
        in_ch.last   = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        out_ch.ready = 1'b0;
        digit_passes = dlrs_pkg::DigitsReset;
        batch_dropped = 1'b0;
        clk_gap(6);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_digit_settings();
        test_overflow_stall();
        test_random_batches();
        drain();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: sim.f
src/dlrs_pkg.sv
src/dlrs_if.sv
src/decimal_lsd_radix_sort_top.sv
tb/tb_decimal_lsd_radix_sort_top.sv
